FILE: hdl/gblur_pkg.sv
// Shared constants, payload types and helper types of the 3x3 Gaussian blur.
package gblur_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT + 2);
  localparam int SUM_W     = PIX_W + 4;
  localparam int LINE_W    = 2 * PIX_W;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(240);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             drain;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_item_t;

  // Which neighbors of the center pixel lie inside the frame.
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } border_t;

  // Window taps, row-major: 0..2 top row, 3..5 middle row, 6..8 bottom row.
  typedef logic [8:0][PIX_W-1:0] window_t;

endpackage

FILE: hdl/gaussian_blur_3x3.sv
// Top level of the 3x3 Gaussian blur over a raster stream of grey pixels.
// A result is loaded into the output register when the input stage holding the input item that
// completes it advances; that item comes width+1 positions after the center pixel.
// Throughput: one item per cycle unless the output stalls, with a line store RAM read per transfer.
// Reset loads 320x240, clears the position counters, the window and the pipeline valids.
// The line store is not cleared: every entry that reaches a result was written in the frame.
module gaussian_blur_3x3 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gblur_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gblur_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [gblur_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gblur_pkg::CFG_W-1:0]         cfg_data
);

  localparam int PIX_W  = gblur_pkg::PIX_W;
  localparam int CFG_W  = gblur_pkg::CFG_W;
  localparam int COL_W  = gblur_pkg::COL_W;
  localparam int ROW_W  = gblur_pkg::ROW_W;
  localparam int LINE_W = gblur_pkg::LINE_W;

  // Configuration and position.
  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CFG_W-1:0] w_eff, h_eff;

  // Input stage.
  logic                  s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]      s1_px_r;
  logic [COL_W-1:0]      s1_col_r;
  logic                  s1_emit_r;
  logic                  s1_last_r;
  gblur_pkg::border_t    s1_border_r;
  logic                  s1_byp_r;
  logic [LINE_W-1:0]     s1_byp_data_r;

  // Window and output register.
  gblur_pkg::window_t    win_r, win_nxt;
  logic                  out_valid_r, out_valid_nxt;
  gblur_pkg::out_item_t  out_data_r;

  logic                  accept, adv;
  logic                  emit, last;
  logic [ROW_W-1:0]      cr;
  logic [COL_W-1:0]      cc;
  gblur_pkg::border_t    border;
  logic [LINE_W-1:0]     ram_rdata, line_word, wr_data;
  logic [PIX_W-1:0]      blur_px;

  always_comb begin
    if (width_r == '0) begin
      w_eff = CFG_W'(1);
    end else if (32'(width_r) > gblur_pkg::MAX_WIDTH) begin
      w_eff = CFG_W'(gblur_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = CFG_W'(1);
    end else if (32'(height_r) > gblur_pkg::MAX_HEIGHT) begin
      h_eff = CFG_W'(gblur_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // The input stage moves on when the output register is free or being emptied.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign accept   = in_valid && in_ready;

  // Center pixel of the result caused by the item at the current position.
  always_comb begin
    emit = (32'(row_r) >= 2) || (32'(row_r) == 1 && col_r != '0);
    if (col_r == '0) begin
      cr = row_r - ROW_W'(2);
      cc = COL_W'(w_eff - CFG_W'(1));
    end else begin
      cr = row_r - ROW_W'(1);
      cc = col_r - COL_W'(1);
    end
    border.up    = cr != '0;
    border.down  = 32'(cr) < 32'(h_eff) - 1;
    border.left  = cc != '0;
    border.right = 32'(cc) < 32'(w_eff) - 1;
    last = (32'(cr) == 32'(h_eff) - 1) && (32'(cc) == 32'(w_eff) - 1);
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (accept) begin
      if (32'(col_r) + 1 >= 32'(w_eff)) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (emit && last) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
    // A register write restarts the frame.
    if (cfg_we) begin
      unique case (cfg_index)
        gblur_pkg::REG_IMAGE_WIDTH: begin
          width_nxt = cfg_data;
          col_nxt   = '0;
          row_nxt   = '0;
        end
        gblur_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt = cfg_data;
          col_nxt    = '0;
          row_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Line store word: upper byte two rows back, lower byte one row back.
  gblur_ram #(
    .WIDTH (LINE_W),
    .DEPTH (gblur_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_col_r),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // When the read hits the word being written in the same cycle, the written
  // value is captured and used instead of the stale RAM data.
  assign line_word = s1_byp_r ? s1_byp_data_r : ram_rdata;
  assign wr_data   = {line_word[PIX_W-1:0], s1_px_r};

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = line_word[LINE_W-1:PIX_W];
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = line_word[PIX_W-1:0];
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_px_r;
  end

  gblur_kernel u_kernel (
    .win    (win_nxt),
    .border (s1_border_r),
    .pixel  (blur_px)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && s1_emit_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= gblur_pkg::WIDTH_RESET;
      height_r    <= gblur_pkg::HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r       <= in_data.drain ? '0 : in_data.pixel_in;
      s1_col_r      <= col_r;
      s1_emit_r     <= emit;
      s1_last_r     <= last;
      s1_border_r   <= border;
      s1_byp_r      <= adv && (s1_col_r == col_r);
      s1_byp_data_r <= wr_data;
    end
    if (adv && s1_emit_r) begin
      out_data_r.pixel_out <= blur_px;
      out_data_r.frame_end <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/gblur_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gblur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/gblur_kernel.sv
// Weighted 1-2-1 / 2-4-2 / 1-2-1 sum over the window with border masking.
module gblur_kernel (
  input  gblur_pkg::window_t              win,
  input  gblur_pkg::border_t              border,
  output logic [gblur_pkg::PIX_W-1:0]     pixel
);

  localparam int SW = gblur_pkg::SUM_W;

  logic [SW-1:0] sum;

  always_comb begin
    sum = SW'({win[4], 2'b00});
    if (border.up) begin
      sum = sum + SW'({win[1], 1'b0});
      if (border.left) begin
        sum = sum + SW'(win[0]);
      end
      if (border.right) begin
        sum = sum + SW'(win[2]);
      end
    end
    if (border.down) begin
      sum = sum + SW'({win[7], 1'b0});
      if (border.left) begin
        sum = sum + SW'(win[6]);
      end
      if (border.right) begin
        sum = sum + SW'(win[8]);
      end
    end
    if (border.left) begin
      sum = sum + SW'({win[3], 1'b0});
    end
    if (border.right) begin
      sum = sum + SW'({win[5], 1'b0});
    end
  end

  // The full kernel weight is 16, so the result is the top bits of the sum.
  assign pixel = sum[SW-1:4];

endmodule
